FILE: hdl/tlbpt_pkg.sv
// Shared types and constants for the TLB page table translator.
// No dependencies.
`default_nettype none
package tlbpt_pkg;
	typedef enum logic [1:0] {
		OUT_TLB_HIT   = 2'd0,
		OUT_PT_HIT    = 2'd1,
		OUT_FAULT     = 2'd2,
		OUT_RESERVED  = 2'd3
	} outcome_t;

	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned PHYS_W  = 15;
	localparam int unsigned PAGE_W  = 8;
	localparam int unsigned STAMP_W = 32;
	localparam logic        POLICY_FIFO = 1'b0;
	localparam logic        POLICY_LRU  = 1'b1;
endpackage
`default_nettype wire

FILE: hdl/tlbpt_tlb.sv
// Fully associative TLB with round-robin refill and invalidation by page.
// Depends on tlbpt_pkg.
`default_nettype none
module tlbpt_tlb #(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned FR_W    = 7
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [tlbpt_pkg::PAGE_W-1:0] lookup_page,
	output logic                           hit,
	output logic [FR_W-1:0]                hit_frame,
	input  wire logic                      inval_en,
	input  wire logic [tlbpt_pkg::PAGE_W-1:0] inval_page,
	input  wire logic                      ins_en,
	input  wire logic [tlbpt_pkg::PAGE_W-1:0] ins_page,
	input  wire logic [FR_W-1:0]           ins_frame
);
	import tlbpt_pkg::*;
	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [PAGE_W-1:0] tag_q [ENTRIES];
	logic [FR_W-1:0]   frame_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0]     next_q;

	// Lowest matching valid entry wins.
	always_comb begin
		hit = 1'b0;
		hit_frame = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == lookup_page) begin
				hit = 1'b1;
				hit_frame = frame_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			next_q <= '0;
		end else begin
			if (inval_en) begin
				for (int i = 0; i < ENTRIES; i++)
					if (valid_q[i] && tag_q[i] == inval_page)
						valid_q[i] <= 1'b0;
			end
			if (ins_en) begin
				valid_q[next_q] <= 1'b1;
				next_q <= (next_q == IW'(ENTRIES - 1)) ? '0 : next_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			tag_q[next_q] <= ins_page;
			frame_q[next_q] <= ins_frame;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/tlb_page_table_translator.sv
// Top level of the TLB page table translator.
// Depends on tlbpt_pkg and tlbpt_tlb.
// One transaction at a time. A fault first scans the frames in order for a free one,
// reading one frame at a time. With all frames in use, FIFO takes the next frame in
// turn, while LRU adds a stamp scan that reads one frame per cycle and picks the frame
// with the smallest stamp. The next input is taken in the cycle after the result is
// accepted. After reset the block clears its page and frame bits before taking the
// first transaction.
`default_nettype none
module tlb_page_table_translator #(
	parameter int unsigned TLB_ENTRIES = 16,
	parameter int unsigned FRAMES      = 128,
	parameter int unsigned PAGES       = 256,
	parameter int unsigned OFFSET_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [tlbpt_pkg::ADDR_W-1:0]  logical_address,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [tlbpt_pkg::PHYS_W-1:0]       physical_address,
	output logic [1:0]                         outcome,
	output logic [tlbpt_pkg::PAGE_W-1:0]       fetch_page,
	output logic                               evicted_valid,
	output logic [tlbpt_pkg::PAGE_W-1:0]       evicted_page
);
	import tlbpt_pkg::*;
	localparam int unsigned FR_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned PG_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int unsigned CLR_N = (PAGES > FRAMES) ? PAGES : FRAMES;
	localparam int unsigned CLR_W = $clog2(CLR_N + 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LOOK, S_PT, S_FREE_RD, S_FREE, S_LRU_RD, S_LRU,
		S_EVICT_RD, S_EVICT, S_COMMIT, S_STAMP, S_OUT
	} state_t;

	state_t state_q;
	logic              policy_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [PG_W-1:0]   page_q;
	logic [FR_W-1:0]   frame_q;
	logic [FR_W-1:0]   scan_q;
	logic [FR_W-1:0]   fifo_q;
	logic [STAMP_W-1:0] count_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [FR_W-1:0]   best_q;
	logic [CLR_W-1:0]  clr_q;
	logic [1:0]        outc_q;
	logic              ev_q;
	logic [PG_W-1:0]   evp_q;

	// Memories: read data is registered, valid in the cycle after the address.
	logic [FR_W-1:0]    page_frame_m [PAGES];
	logic               page_pres_m  [PAGES];
	logic [PG_W-1:0]    owner_m      [FRAMES];
	logic               used_m       [FRAMES];
	logic [STAMP_W-1:0] stamp_m      [FRAMES];
	logic [FR_W-1:0]    pf_rd_q;
	logic               pp_rd_q;
	logic [PG_W-1:0]    own_rd_q;
	logic               used_rd_q;
	logic [STAMP_W-1:0] stamp_rd_q;

	logic [PG_W-1:0] in_page;
	logic tlb_hit;
	logic [FR_W-1:0] tlb_frame;
	logic [PAGE_W-1:0] page_ext, evp_ext;

	assign in_page  = PG_W'(logical_address[ADDR_W-1:OFFSET_BITS] % PAGES);
	assign page_ext = PAGE_W'(page_q);
	assign evp_ext  = PAGE_W'(evp_q);

	tlbpt_tlb #(.ENTRIES(TLB_ENTRIES), .FR_W(FR_W)) u_tlb (
		.clk(clk), .arst_n(arst_n),
		.lookup_page(page_ext), .hit(tlb_hit), .hit_frame(tlb_frame),
		.inval_en(state_q == S_EVICT), .inval_page(PAGE_W'(own_rd_q)),
		.ins_en(state_q == S_COMMIT), .ins_page(page_ext), .ins_frame(frame_q)
	);

	// Memory read addresses by state.
	logic [FR_W-1:0] fr_addr;
	always_comb begin
		fr_addr = scan_q;
		if (state_q == S_EVICT_RD)
			fr_addr = frame_q;
	end

	always_ff @(posedge clk) begin
		pf_rd_q    <= page_frame_m[page_q];
		pp_rd_q    <= page_pres_m[page_q];
		own_rd_q   <= owner_m[fr_addr];
		used_rd_q  <= used_m[fr_addr];
		stamp_rd_q <= stamp_m[fr_addr];
		if (state_q == S_CLEAR) begin
			if (clr_q < CLR_W'(PAGES))
				page_pres_m[clr_q[PG_W-1:0]] <= 1'b0;
			if (clr_q < CLR_W'(FRAMES))
				used_m[clr_q[FR_W-1:0]] <= 1'b0;
		end
		if (state_q == S_EVICT)
			page_pres_m[own_rd_q] <= 1'b0;
		if (state_q == S_COMMIT && outc_q == OUT_FAULT) begin
			page_frame_m[page_q] <= frame_q;
			page_pres_m[page_q]  <= 1'b1;
			owner_m[frame_q]     <= page_q;
			used_m[frame_q]      <= 1'b1;
		end
		if (state_q == S_STAMP)
			stamp_m[frame_q] <= count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			policy_q <= POLICY_FIFO;
			clr_q <= '0;
			fifo_q <= '0;
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we)
				policy_q <= cfg_wdata;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						offset_q <= logical_address[OFFSET_BITS-1:0];
						page_q <= in_page;
						ev_q <= 1'b0;
						evp_q <= '0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					// Page table read is in flight; TLB compare is combinational.
					if (tlb_hit) begin
						frame_q <= tlb_frame;
						outc_q <= OUT_TLB_HIT;
						state_q <= S_STAMP;
					end else begin
						state_q <= S_PT;
					end
				end
				S_PT: begin
					if (pp_rd_q) begin
						frame_q <= pf_rd_q;
						outc_q <= OUT_PT_HIT;
						state_q <= S_COMMIT;
					end else begin
						outc_q <= OUT_FAULT;
						scan_q <= '0;
						state_q <= S_FREE_RD;
					end
				end
				S_FREE_RD: state_q <= S_FREE;
				S_FREE: begin
					if (!used_rd_q) begin
						frame_q <= scan_q;
						state_q <= S_COMMIT;
					end else if (scan_q == FR_W'(FRAMES - 1)) begin
						if (policy_q == POLICY_FIFO) begin
							frame_q <= fifo_q;
							fifo_q <= (fifo_q == FR_W'(FRAMES - 1)) ? '0 : fifo_q + 1'b1;
							state_q <= S_EVICT_RD;
						end else begin
							scan_q <= '0;
							state_q <= S_LRU_RD;
						end
					end else begin
						scan_q <= scan_q + 1'b1;
						state_q <= S_FREE_RD;
					end
				end
				S_LRU_RD: begin
					scan_q <= scan_q + 1'b1;
					state_q <= S_LRU;
				end
				S_LRU: begin
					// stamp_rd_q belongs to frame scan_q-1; pipeline one read per cycle.
					if (scan_q == FR_W'(1) || stamp_rd_q < best_stamp_q) begin
						best_stamp_q <= stamp_rd_q;
						best_q <= scan_q - 1'b1;
					end
					if (scan_q == '0) begin
						frame_q <= (stamp_rd_q < best_stamp_q) ? FR_W'(FRAMES - 1) : best_q;
						state_q <= S_EVICT_RD;
					end else begin
						scan_q <= (scan_q == FR_W'(FRAMES - 1)) ? '0 : scan_q + 1'b1;
					end
				end
				S_EVICT_RD: state_q <= S_EVICT;
				S_EVICT: begin
					ev_q <= 1'b1;
					evp_q <= own_rd_q;
					state_q <= S_COMMIT;
				end
				S_COMMIT: state_q <= S_STAMP;
				S_STAMP: begin
					count_q <= count_q + 1'b1;
					out_valid <= 1'b1;
					physical_address <= PHYS_W'({frame_q, offset_q});
					outcome <= outc_q;
					fetch_page <= (outc_q == OUT_FAULT) ? page_ext : '0;
					evicted_valid <= ev_q;
					evicted_page <= evp_ext;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
endmodule
`default_nettype wire

FILE: hdl/tlbpt_checker.sv
// Port-level checks for the translator, bound to the top level.
// Depends on tlbpt_pkg.
`default_nettype none
module tlbpt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] outcome,
	input wire logic [7:0] fetch_page,
	input wire logic       evicted_valid
);
	import tlbpt_pkg::*;
	// One transaction in flight: no input taken while a result waits.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready)) else $error("input accepted during result");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outcome != OUT_RESERVED) else $error("bad outcome");
	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && evicted_valid) |-> outcome == OUT_FAULT)
		else $error("eviction without fault");
	a_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && outcome != OUT_FAULT) |-> fetch_page == 8'd0)
		else $error("fetch page on hit");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind tlb_page_table_translator tlbpt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .outcome(outcome),
	.fetch_page(fetch_page), .evicted_valid(evicted_valid)
);
`default_nettype wire

FILE: tb/tb_tlb_page_table_translator.sv
// Testbench for the TLB page table translator: drives logical addresses under
// both replacement policies and checks every result against a behavioral predictor.
// Depends on tlbpt_pkg and tlb_page_table_translator.
`timescale 1ns / 100ps
`default_nettype none

class translation_scoreboard;
	typedef struct packed {
		logic [14:0] phys;
		logic [1:0]  outcome;
		logic [7:0]  fetch;
		logic        ev_valid;
		logic [7:0]  ev_page;
	} translation_t;

	bit             lru_mode;
	logic [7:0]     tlb_tag [16];
	bit             tlb_valid [16];
	logic [6:0]     tlb_frame [16];
	logic [3:0]     tlb_next;
	logic [6:0]     page_frame [256];
	bit             page_present [256];
	logic [7:0]     frame_owner [128];
	bit             frame_used [128];
	logic [6:0]     fifo_next;
	logic [31:0]    frame_stamp [128];
	logic [31:0]    access_count;
	translation_t   pending_translations [$];
	int             mismatches;

	function new();
		tlb_next = 0;
		fifo_next = 0;
		access_count = 0;
		lru_mode = 0;
		mismatches = 0;
		foreach (tlb_valid[i]) tlb_valid[i] = 0;
		foreach (page_present[i]) page_present[i] = 0;
		foreach (frame_used[i]) frame_used[i] = 0;
	endfunction

	function void refill_tlb(logic [7:0] pg, logic [6:0] fr);
		tlb_tag[tlb_next] = pg;
		tlb_frame[tlb_next] = fr;
		tlb_valid[tlb_next] = 1;
		tlb_next = tlb_next + 4'd1;
	endfunction

	// Works out the translation of one accepted address and queues it.
	function void note_address(logic [15:0] addr);
		translation_t t;
		logic [7:0] pg;
		logic [7:0] old;
		logic [6:0] fr;
		bit hit;
		bit found;
		int best;
		pg = addr[15:8];
		fr = 0;
		hit = 0;
		t = '0;
		for (int i = 0; i < 16; i++) begin
			if (!hit && tlb_valid[i] && tlb_tag[i] == pg) begin
				fr = tlb_frame[i];
				hit = 1;
			end
		end
		if (hit) begin
			t.outcome = tlbpt_pkg::OUT_TLB_HIT;
		end else if (page_present[pg]) begin
			fr = page_frame[pg];
			refill_tlb(pg, fr);
			t.outcome = tlbpt_pkg::OUT_PT_HIT;
		end else begin
			found = 0;
			for (int i = 0; i < 128; i++) begin
				if (!found && !frame_used[i]) begin
					fr = 7'(i);
					found = 1;
				end
			end
			if (!found) begin
				if (lru_mode == tlbpt_pkg::POLICY_FIFO) begin
					fr = fifo_next;
					fifo_next = fifo_next + 7'd1;
				end else begin
					best = 0;
					for (int i = 1; i < 128; i++)
						if (frame_stamp[i] < frame_stamp[best]) best = i;
					fr = 7'(best);
				end
				old = frame_owner[fr];
				page_present[old] = 0;
				for (int i = 0; i < 16; i++)
					if (tlb_valid[i] && tlb_tag[i] == old) tlb_valid[i] = 0;
				t.ev_valid = 1;
				t.ev_page = old;
			end
			page_frame[pg] = fr;
			page_present[pg] = 1;
			frame_owner[fr] = pg;
			frame_used[fr] = 1;
			refill_tlb(pg, fr);
			t.outcome = tlbpt_pkg::OUT_FAULT;
			t.fetch = pg;
		end
		frame_stamp[fr] = access_count;
		access_count = access_count + 32'd1;
		t.phys = {fr, addr[7:0]};
		pending_translations.push_back(t);
	endfunction

	task report(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	task check_translation(translation_t got);
		translation_t want;
		if (pending_translations.size() == 0) begin
			$display("mismatch: result arrived with nothing expected");
			mismatches++;
			return;
		end
		want = pending_translations.pop_front();
		if (got.phys !== want.phys)
			report("physical_address", 16'(got.phys), 16'(want.phys));
		if (got.outcome !== want.outcome)
			report("outcome", 16'(got.outcome), 16'(want.outcome));
		if (got.fetch !== want.fetch)
			report("fetch_page", 16'(got.fetch), 16'(want.fetch));
		if (got.ev_valid !== want.ev_valid)
			report("evicted_valid", 16'(got.ev_valid), 16'(want.ev_valid));
		if (got.ev_page !== want.ev_page)
			report("evicted_page", 16'(got.ev_page), 16'(want.ev_page));
	endtask
endclass

module tb_tlb_page_table_translator;
	import tlbpt_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_wdata = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [ADDR_W-1:0] logical_address = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [PHYS_W-1:0] physical_address;
	logic [1:0] outcome;
	logic [PAGE_W-1:0] fetch_page;
	logic evicted_valid;
	logic [PAGE_W-1:0] evicted_page;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	bit receiver_hold = 0;
	int cycle_count = 0;
	translation_scoreboard board;

	tlb_page_table_translator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .logical_address(logical_address),
		.out_valid(out_valid), .out_ready(out_ready), .physical_address(physical_address),
		.outcome(outcome), .fetch_page(fetch_page), .evicted_valid(evicted_valid),
		.evicted_page(evicted_page)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Input and output transactions are observed at the same edge the block sees.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) board.note_address(logical_address);
		if (arst_n && out_valid && out_ready)
			board.check_translation({physical_address, outcome, fetch_page,
				evicted_valid, evicted_page});
	end

	always @(posedge clk) begin
		if (receiver_hold)
			out_ready <= 0;
		else
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Valid drops only while the sender idles, so back-to-back items keep it high.
	task automatic send_address(logic [15:0] addr);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		logical_address <= addr;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (board.pending_translations.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_policy(bit lru);
		cfg_we <= 1;
		cfg_wdata <= lru;
		@(posedge clk);
		cfg_we <= 0;
		board.lru_mode = lru;
	endtask

	// Pages below span, one address in ten anywhere, so hits, refills and evictions all occur.
	function automatic logic [15:0] random_address(int span);
		logic [7:0] pg;
		if ($urandom_range(9) == 0) return 16'($urandom);
		pg = 8'($urandom_range(span - 1));
		return {pg, 8'($urandom)};
	endfunction

	initial begin
		int spans[4] = '{8, 140, 200, 256};
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		repeat (300) @(posedge clk);

		// Directed: extremes, repeats for TLB and page table hits.
		send_address(16'h0000);
		send_address(16'h00FF);
		send_address(16'hFFFF);
		send_address(16'hFF00);
		send_address(16'h0055);
		for (int p = 1; p <= 17; p++) send_address({8'(p), 8'hAA});
		send_address(16'h0001);
		send_address(16'hFF7F);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			set_policy(phase[0]);
			case (phase % 4)
				0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
				1: begin sender_idle_pct = 83; receiver_stall_pct = 0; end
				2: begin sender_idle_pct = 0; receiver_stall_pct = 83; end
				default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
			endcase
			if (phase == 4) begin
				fork
					begin
						receiver_hold = 1;
						repeat (400) @(posedge clk);
						receiver_hold = 0;
					end
				join_none
			end
			for (int n = 0; n < 235; n++) send_address(random_address(spans[phase % 4]));
			drain();
		end

		if (board.mismatches == 0 && board.pending_translations.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

FILE: sim.f
hdl/tlbpt_pkg.sv
hdl/tlbpt_tlb.sv
hdl/tlb_page_table_translator.sv
hdl/tlbpt_checker.sv
tb/tb_tlb_page_table_translator.sv
